// ----- rtl/wapd_pkg.sv -----
`timescale 1ns / 1ps

package wapd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 2;

  // Number of channels that the channel field can address at all.
  localparam int CHAN_CODES = 1 << CHAN_W;

  localparam logic [SAMPLE_W-1:0] MIN_RESET    = 12'd4095;
  localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd64;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CHAN_W-1:0]   chan_t;

endpackage

// ----- rtl/wapd_ram.sv -----
`timescale 1ns / 1ps

module wapd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/windowed_avg_peak_detector_unit.sv -----
`timescale 1ns / 1ps

// Per-channel window statistics for current-transformer converter samples. The block takes
// one sample slot per clock cycle, back to back, including repeated slots for the same
// channel, and passes the slot that closes a window through stage 1, stage 2 and the output
// register to give a result (average, peak-to-peak and current-on flag). The per-channel
// sum, minimum, maximum and slot count live in a small RAM with a registered read; every
// slot reads its entry, updates it and writes it back from stage 1, and a one-entry
// write-forwarding register covers a slot that follows directly on the same channel. The
// average is formed by multiplying the sum by a fixed reciprocal of the window length. Input
// is only held off when a result waits at the output and a second result is already queued
// behind it. Entries carry valid bits, so the block is ready straight after reset with no
// clearing pass. Slots naming a channel beyond the configured count are taken and discarded.
module windowed_avg_peak_detector_unit
  import wapd_pkg::*;
#(
  parameter int WINDOW_SLOTS = 48,
  parameter int NUM_CHANNELS = 3
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SAMPLE_W-1:0] cfg_on_threshold,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_sample_ok,
  input  logic                in_close_early,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAN_W-1:0]   out_channel,
  output logic [SAMPLE_W-1:0] out_average,
  output logic [SAMPLE_W-1:0] out_peak_to_peak,
  output logic                out_current_on
);

  localparam int MEM_DEPTH = (NUM_CHANNELS < CHAN_CODES) ? NUM_CHANNELS : CHAN_CODES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SUM_W     = $clog2(WINDOW_SLOTS * 4095 + 1);
  localparam int CNT_W     = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int ENTRY_W   = SUM_W + 2 * SAMPLE_W + CNT_W;

  // Reciprocal of the window length, exact for every sum that SUM_W can hold.
  localparam int SHIFT   = SUM_W + $clog2(WINDOW_SLOTS);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_SLOTS) - 64'd1) / 64'(WINDOW_SLOTS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  localparam logic [ENTRY_W-1:0] RESET_ENTRY =
    {SUM_W'(0), MIN_RESET, SAMPLE_W'(0), CNT_W'(0)};

  logic                blk;
  logic                accept;
  logic                chan_ok;
  logic                s0_take;

  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  sample_t             thr_r;

  logic                s1_valid_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  chan_t               s1_chan_r;
  sample_t             s1_sample_r;
  logic                s1_ok_r;
  logic                s1_early_r;

  logic [MEM_DEPTH-1:0] ent_valid_r;
  logic                 fwd_valid_r;
  logic [ADDR_W-1:0]    fwd_addr_r;
  logic [ENTRY_W-1:0]   fwd_data_r;

  logic [ENTRY_W-1:0]  cur_entry;
  logic [SUM_W-1:0]    cur_sum;
  sample_t             cur_min;
  sample_t             cur_max;
  logic [CNT_W-1:0]    cur_cnt;
  logic [SUM_W-1:0]    upd_sum;
  sample_t             upd_min;
  sample_t             upd_max;
  logic [CNT_W-1:0]    upd_cnt;
  logic                is_last;
  logic                res_fire;
  logic [SUM_W-1:0]    res_sum;
  sample_t             res_min;
  sample_t             res_max;
  sample_t             res_pkpk;

  logic                s2_valid_r;
  chan_t               s2_chan_r;
  logic [SUM_W-1:0]    s2_sum_r;
  sample_t             s2_pkpk_r;
  logic [PROD_W-1:0]   s2_prod;
  logic                s2_on;

  logic                out_valid_r;
  chan_t               out_chan_r;
  sample_t             out_avg_r;
  sample_t             out_pkpk_r;
  logic                out_on_r;

  // The pipeline only freezes when a finished result cannot move into the output register.
  assign blk      = s2_valid_r && out_valid_r && out_stall;
  assign in_stall = blk;
  assign accept   = in_valid && !blk;
  assign chan_ok  = (32'(in_channel) < NUM_CHANNELS);
  assign s0_take  = accept && chan_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_on_threshold;
    end
  end

  wapd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_stats_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (s0_take),
    .raddr (in_channel[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Stage 1: the entry read arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!blk) begin
      s1_valid_r <= s0_take;
    end
  end

  always_ff @(posedge clk) begin
    if (!blk && s0_take) begin
      s1_addr_r   <= in_channel[ADDR_W-1:0];
      s1_chan_r   <= in_channel;
      s1_sample_r <= in_sample;
      s1_ok_r     <= in_sample_ok;
      s1_early_r  <= in_close_early;
    end
  end

  // The latest write may have landed in the same cycle as this entry's read, so it wins.
  always_comb begin
    cur_entry = RESET_ENTRY;
    if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      cur_entry = fwd_data_r;
    end else if (ent_valid_r[s1_addr_r]) begin
      cur_entry = ram_rdata;
    end
  end

  assign {cur_sum, cur_min, cur_max, cur_cnt} = cur_entry;

  always_comb begin
    upd_sum = cur_sum;
    upd_min = cur_min;
    upd_max = cur_max;
    if (s1_ok_r) begin
      upd_sum = cur_sum + SUM_W'(s1_sample_r);
      if (s1_sample_r < cur_min) begin
        upd_min = s1_sample_r;
      end
      if (s1_sample_r > cur_max) begin
        upd_max = s1_sample_r;
      end
    end
    upd_cnt = cur_cnt + CNT_W'(1);
  end

  assign is_last  = (cur_cnt == CNT_W'(WINDOW_SLOTS - 1));
  assign res_fire = s1_valid_r && (s1_early_r || is_last);

  // An early close reports the window as it stands, without this slot.
  assign res_sum  = s1_early_r ? cur_sum : upd_sum;
  assign res_min  = s1_early_r ? cur_min : upd_min;
  assign res_max  = s1_early_r ? cur_max : upd_max;
  assign res_pkpk = (res_max > res_min) ? (res_max - res_min) : '0;

  assign ram_we    = s1_valid_r && !blk;
  assign ram_wdata = res_fire ? RESET_ENTRY : {upd_sum, upd_min, upd_max, upd_cnt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      fwd_valid_r <= 1'b0;
    end else if (ram_we) begin
      ent_valid_r[s1_addr_r] <= 1'b1;
      fwd_valid_r            <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= ram_wdata;
    end
  end

  // Stage 2: closed window waiting for the average multiply.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!blk) begin
      s2_valid_r <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!blk && res_fire) begin
      s2_chan_r <= s1_chan_r;
      s2_sum_r  <= res_sum;
      s2_pkpk_r <= res_pkpk;
    end
  end

  assign s2_prod = PROD_W'(s2_sum_r) * PROD_W'(RECIP);
  assign s2_on   = (s2_pkpk_r >= thr_r);

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!blk && s2_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!blk && s2_valid_r) begin
      out_chan_r <= s2_chan_r;
      out_avg_r  <= s2_prod[SHIFT +: SAMPLE_W];
      out_pkpk_r <= s2_pkpk_r;
      out_on_r   <= s2_on;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_chan_r;
  assign out_average      = out_avg_r;
  assign out_peak_to_peak = out_pkpk_r;
  assign out_current_on   = out_on_r;

  a_cnt_below_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_wdata[CNT_W-1:0] <= CNT_W'(WINDOW_SLOTS - 1)))
    else $error("slot count written back reaches the window length");

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (ram_wdata[CNT_W-1:0] == '0)) |-> (ram_wdata[ENTRY_W-1 -: SUM_W] == '0))
    else $error("empty window written back with a non-zero sum");

  a_blk_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    blk |=> s2_valid_r)
    else $error("queued result lost while the pipeline was held");

  a_result_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !blk) |=> out_valid_r)
    else $error("result left stage 2 without reaching the output register");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import wapd_pkg::*;

  localparam int WINDOW      = 48;
  localparam int NUM_CH      = 3;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    chan_t   chan;
    sample_t average;
    sample_t pk_pk;
    logic    on;
  } window_stats_t;

  logic    clk              = 1'b0;
  logic    rst_n            = 1'b0;
  logic    cfg_valid        = 1'b0;
  logic    cfg_ready;
  sample_t cfg_on_threshold = '0;
  logic    in_valid         = 1'b0;
  logic    in_stall;
  chan_t   in_channel       = '0;
  sample_t in_sample        = '0;
  logic    in_sample_ok     = 1'b0;
  logic    in_close_early   = 1'b0;
  logic    out_valid;
  logic    out_stall        = 1'b0;
  chan_t   out_channel;
  sample_t out_average;
  sample_t out_peak_to_peak;
  logic    out_current_on;

  // Per-channel accumulators as the block should hold them.
  logic [17:0]   acc_sum   [NUM_CH];
  sample_t       acc_min   [NUM_CH];
  sample_t       acc_max   [NUM_CH];
  int unsigned   acc_slots [NUM_CH];
  sample_t       threshold;
  window_stats_t pending_windows[$];

  logic        fast_mode       = 1'b0;
  int          failures        = 0;
  int unsigned slots_counted   = 0;
  int unsigned slots_ignored   = 0;
  int unsigned windows_closed  = 0;
  int unsigned early_closes    = 0;
  int unsigned windows_checked = 0;
  int unsigned thresholds_used = 0;
  int unsigned cycle_count     = 0;
  int unsigned stall_left      = 0;

  windowed_avg_peak_detector_unit #(
    .WINDOW_SLOTS(WINDOW),
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_on_threshold(cfg_on_threshold),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_channel      (in_channel),
    .in_sample       (in_sample),
    .in_sample_ok    (in_sample_ok),
    .in_close_early  (in_close_early),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel     (out_channel),
    .out_average     (out_average),
    .out_peak_to_peak(out_peak_to_peak),
    .out_current_on  (out_current_on)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d windows outstanding.", cycle_count,
               pending_windows.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic void clear_acc(input int c);
    acc_sum[c]   = '0;
    acc_min[c]   = MIN_RESET;
    acc_max[c]   = '0;
    acc_slots[c] = 0;
  endfunction

  function automatic void close_window(input int c);
    window_stats_t w;
    w.chan    = chan_t'(c);
    w.average = sample_t'(acc_sum[c] / WINDOW);
    w.pk_pk   = (acc_max[c] > acc_min[c]) ? acc_max[c] - acc_min[c] : '0;
    w.on      = (w.pk_pk >= threshold);
    pending_windows.push_back(w);
    windows_closed++;
    clear_acc(c);
  endfunction

  function automatic void absorb_slot(input chan_t c, input sample_t s, input logic ok,
                                      input logic early);
    if (int'(c) >= NUM_CH) begin
      slots_ignored++;
      return;
    end
    slots_counted++;
    if (early) begin
      early_closes++;
      close_window(int'(c));
      return;
    end
    if (ok) begin
      acc_sum[c] = acc_sum[c] + 18'(s);
      if (s < acc_min[c]) acc_min[c] = s;
      if (s > acc_max[c]) acc_max[c] = s;
    end
    acc_slots[c]++;
    if (acc_slots[c] >= WINDOW) close_window(int'(c));
  endfunction

  function automatic string describe(input window_stats_t w);
    return $sformatf("ch=%0d avg=%0d pkpk=%0d on=%0b", w.chan, w.average, w.pk_pk, w.on);
  endfunction

  function automatic void flag_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endfunction

  // A sample in a band around base, now and then pinned to an end of the range.
  function automatic sample_t band_sample(input int unsigned base, input int unsigned span);
    int v;
    v = int'(base) + int'($urandom_range(0, span - 1)) - int'(span / 2);
    if ($urandom_range(0, 24) == 0) v = $urandom_range(0, 1) ? 4095 : 0;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  // Result side: check every transfer, then stall for a freshly drawn number of cycles.
  always @(posedge clk) begin
    window_stats_t got;
    window_stats_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_channel, out_average, out_peak_to_peak, out_current_on};
        if (pending_windows.size() == 0) begin
          flag_failure({"result with none expected: ", describe(got)});
        end else begin
          want = pending_windows.pop_front();
          windows_checked++;
          if (got.chan !== want.chan || got.average !== want.average ||
              got.pk_pk !== want.pk_pk || got.on !== want.on) begin
            flag_failure({"expected ", describe(want), ", got ", describe(got)});
          end
        end
        stall_left = fast_mode ? 0 : $urandom_range(0, 5);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_slot(input chan_t c, input sample_t s, input logic ok,
                           input logic early);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_channel     <= c;
    in_sample      <= s;
    in_sample_ok   <= ok;
    in_close_early <= early;
    do @(posedge clk); while (in_stall);
    absorb_slot(c, s, ok, early);
  endtask

  // Slots that close nothing may still be in the pipeline, so allow a few more cycles.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input sample_t value);
    wait_idle();
    cfg_valid        <= 1'b1;
    cfg_on_threshold <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = value;
    thresholds_used++;
  endtask

  task automatic random_burst();
    chan_t       c;
    int unsigned base;
    int unsigned span;
    int unsigned len;
    logic        ok;
    logic        early;
    c    = ($urandom_range(0, 19) == 0) ? chan_t'(CHAN_CODES - 1)
                                         : chan_t'($urandom_range(0, NUM_CH - 1));
    base = $urandom_range(0, 4095);
    case ($urandom_range(0, 2))
      0: begin
        span = 16;
      end
      1: begin
        span = 256;
      end
      default: begin
        span = 4096;
      end
    endcase
    len = $urandom_range(1, 16);
    repeat (len) begin
      ok    = ($urandom_range(0, 9) != 0);
      early = ($urandom_range(0, 59) == 0);
      send_slot(c, band_sample(base, span), ok, early);
    end
  endtask

  // Runs at the reset threshold of 64, so the reset value is exercised too.
  task automatic test_directed_cases();
    send_slot(2'd0, 12'd0, 1'b1, 1'b1);        // empty window closed early
    send_slot(2'd3, 12'd4095, 1'b1, 1'b0);     // out-of-range channel is dropped
    send_slot(2'd3, 12'd0, 1'b0, 1'b1);
    send_slot(2'd1, 12'd0, 1'b1, 1'b0);
    send_slot(2'd1, 12'd4095, 1'b1, 1'b0);
    send_slot(2'd1, 12'd123, 1'b0, 1'b0);      // counted but skipped
    send_slot(2'd1, 12'd7, 1'b0, 1'b1);
    send_slot(2'd2, 12'd2048, 1'b1, 1'b0);     // max equals min
    send_slot(2'd2, 12'd0, 1'b1, 1'b1);
    send_slot(2'd0, 12'd100, 1'b1, 1'b0);      // just below the threshold
    send_slot(2'd0, 12'd163, 1'b1, 1'b0);
    send_slot(2'd0, 12'd0, 1'b0, 1'b1);
    send_slot(2'd0, 12'd100, 1'b1, 1'b0);      // exactly at the threshold
    send_slot(2'd0, 12'd164, 1'b1, 1'b0);
    send_slot(2'd0, 12'd4095, 1'b0, 1'b1);
    send_slot(2'd1, 12'd4095, 1'b0, 1'b0);     // only failed conversions
    send_slot(2'd1, 12'd4095, 1'b0, 1'b0);
    send_slot(2'd1, 12'd0, 1'b0, 1'b1);
  endtask

  task automatic test_threshold_zero();
    chan_t c;
    write_threshold('0);
    send_slot(2'd2, 12'd0, 1'b0, 1'b1);
    // A full window of the largest sample gives the largest average.
    c = chan_t'($urandom_range(0, NUM_CH - 1));
    fast_mode = ($urandom_range(0, 1) == 1);
    repeat (WINDOW) send_slot(c, 12'd4095, 1'b1, 1'b0);
    fast_mode = 1'b0;
    c = chan_t'((int'(c) + 1) % NUM_CH);
    repeat (WINDOW) send_slot(c, sample_t'($urandom_range(0, 4095)), 1'b0, 1'b0);
  endtask

  task automatic test_threshold_max();
    write_threshold(12'd4095);
    send_slot(2'd0, 12'd0, 1'b1, 1'b0);
    send_slot(2'd0, 12'd4095, 1'b1, 1'b0);
    send_slot(2'd0, 12'd0, 1'b0, 1'b1);
    send_slot(2'd2, 12'd1, 1'b1, 1'b0);
    send_slot(2'd2, 12'd4095, 1'b1, 1'b0);
    send_slot(2'd2, 12'd0, 1'b0, 1'b1);
  endtask

  // No idling on either side, with runs of slots on the same channel.
  task automatic test_back_to_back();
    write_threshold(sample_t'($urandom_range(0, 300)));
    fast_mode = 1'b1;
    repeat (12) random_burst();
    fast_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    sample_t     t;
    start = slots_counted;
    for (int phase = 0; phase < 4; phase++) begin
      t = (phase == 0) ? sample_t'($urandom_range(0, 4095))
                       : sample_t'($urandom_range(1, 400));
      write_threshold(t);
      while (slots_counted - start < 120 * (phase + 1) && slots_counted - start < 3000) begin
        fast_mode = ($urandom_range(0, 5) == 0);
        random_burst();
      end
      fast_mode = 1'b0;
    end
  endtask

  initial begin
    for (int c = 0; c < NUM_CH; c++) clear_acc(c);
    threshold = THRESH_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_threshold_zero();
    test_threshold_max();
    test_back_to_back();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (pending_windows.size() != 0) begin
      flag_failure($sformatf("%0d expected windows never arrived", pending_windows.size()));
    end
    $display("Checked %0d closed windows (%0d closed early) from %0d sample slots.",
             windows_checked, early_closes, slots_counted);
    $display("Also sent %0d out-of-range slots; %0d threshold settings; %0d failures.",
             slots_ignored, thresholds_used, failures);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wapd_pkg.sv
rtl/wapd_ram.sv
rtl/windowed_avg_peak_detector_unit.sv
sim/testbench.sv
